FILE: rtl/lz3_pkg.sv
// Shared types, constants and the Lanczos-3 weight table for the line downscaler.
// Depends on nothing; every other file but lz3_ram imports it.
package lz3_pkg;

    localparam int MAX_LEN      = 4096;
    localparam int WINDOW_DEPTH = 128;
    localparam int MAX_RATIO    = 16;
    localparam int WEIGHT_STEPS = 64;
    localparam int RESULT_CAP   = 5;
    localparam int TAB_LEN      = 3 * WEIGHT_STEPS;
    localparam int IDX_W        = $clog2(TAB_LEN);
    localparam int RING_AW      = $clog2(WINDOW_DEPTH);

    // Field and datapath widths.
    localparam int LEN_W    = 13;
    localparam int SAMPLE_W = 16;
    localparam int DVD_W    = 42;
    localparam int DVS_W    = 24;

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned PI2_Q30 = 64'd10597407032;

    typedef logic [TAB_LEN-1:0][15:0] lz3_weight_tab_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CALC_C,
        S_DIV_HI,
        S_TEST,
        S_DIV_LO,
        S_DIV_INIT,
        S_DIV_STEP,
        S_TAPS,
        S_DRAIN,
        S_DIV_OUT,
        S_EMIT,
        S_FINISH
    } lz3_state_t;

    typedef enum logic [2:0] {
        DOP_HI,
        DOP_LO,
        DOP_INIT,
        DOP_STEP,
        DOP_OUT
    } lz3_div_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load_item;
        logic        calc_c;
        logic        div_start;
        lz3_div_op_t div_op;
        logic        take_hi;
        logic        take_lo;
        logic        take_init;
        logic        take_step;
        logic        tap_issue;
        logic        take_out;
        logic        out_write;
        logic        finish;
    } lz3_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic can_output;
        logic not_ready;
        logic tap_last;
        logic pipe_busy;
        logic out_direct;
        logic out_free;
    } lz3_stat_t;

    // Magnitude of sin(pi*n/TAB_LEN) in Q30, sign flag in the top bit.
    function automatic logic [64:0] sin_q30(input longint unsigned n);
        longint unsigned m;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        logic            neg;
        m   = n % (2 * TAB_LEN);
        neg = 1'b0;
        if (m >= TAB_LEN)
        begin
            m   = m - TAB_LEN;
            neg = 1'b1;
        end
        if (2 * m > TAB_LEN)
        begin
            m = TAB_LEN - m;
        end
        u  = (m * PI_Q30 + TAB_LEN / 2) / TAB_LEN;
        u2 = (u * u) >> 30;
        t  = Q30_ONE - ((u2 * Q30_ONE) >> 30) / 110;
        t  = Q30_ONE - ((u2 * t) >> 30) / 72;
        t  = Q30_ONE - ((u2 * t) >> 30) / 42;
        t  = Q30_ONE - ((u2 * t) >> 30) / 20;
        t  = Q30_ONE - ((u2 * t) >> 30) / 6;
        return {neg, (u * t) >> 30};
    endfunction

    // Shift-and-subtract quotient, used only while building the table.
    function automatic longint unsigned long_quot(input longint unsigned a,
                                                  input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        int              j;
        q = 0;
        r = 0;
        for (j = 63; j >= 0; j--)
        begin
            r = {r[62:0], a[j]};
            if (r >= b)
            begin
                r    = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // Lanczos-3 weights in Q1.15, one entry per 1/WEIGHT_STEPS of distance.
    function automatic lz3_weight_tab_t build_lz_table();
        lz3_weight_tab_t tab;
        logic [64:0]     s1;
        logic [64:0]     s2;
        longint unsigned ii;
        longint unsigned p;
        longint unsigned q;
        longint unsigned l;
        int              i;
        tab[0] = 16'd32767;
        for (i = 1; i < TAB_LEN; i++)
        begin
            ii = longint'(i);
            // sin(pi*i/WEIGHT_STEPS) is sin(pi*3i/TAB_LEN).
            s1 = sin_q30(3 * ii);
            s2 = sin_q30(ii);
            p  = (s1[63:0] * s2[63:0]) >> 30;
            q  = long_quot(p * 3 * WEIGHT_STEPS * WEIGHT_STEPS, ii * ii);
            l  = (q * 32768 + PI2_Q30 / 2) / PI2_Q30;
            if (l > 32767)
            begin
                l = 32767;
            end
            if (s1[64] != s2[64])
            begin
                tab[i] = ~l[15:0] + 16'd1;
            end
            else
            begin
                tab[i] = l[15:0];
            end
        end
        return tab;
    endfunction

    localparam lz3_weight_tab_t LZ_TABLE = build_lz_table();

endpackage

FILE: rtl/lz3_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lz3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/lz3_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on lz3_pkg for operand widths.
module lz3_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lz3_pkg::DVD_W-1:0]      dividend,
    input  logic [lz3_pkg::DVS_W-1:0]      divisor,
    output logic [lz3_pkg::DVD_W-1:0]      quotient,
    output logic [lz3_pkg::DVS_W-1:0]      remainder,
    output logic                           done
);
    import lz3_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;

    // One shift and trial subtract per cycle.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg[DVS_W-1:0];
    assign done      = done_reg;

    // A new division never starts on top of a running one.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    // The remainder always stays below the divisor once finished.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < {1'b0, dvs_reg}) || (dvs_reg == '0))
        else $error("divider remainder out of range");

    // Done follows the last iteration only.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule

FILE: rtl/lz3_ctrl.sv
// Sequencing state machine: per sample it walks outputs, divisions and tap passes.
// Depends on lz3_pkg for the state, command and status types.
module lz3_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lz3_pkg::lz3_stat_t stat,
    output lz3_pkg::lz3_cmd_t  cmd
);
    import lz3_pkg::*;

    lz3_state_t state_reg, state_next;
    logic       launched_reg, launched_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        cmd           = '0;
        cmd.div_op    = DOP_HI;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.can_output ? S_CALC_C : S_FINISH;
            end
            S_CALC_C:
            begin
                cmd.calc_c = 1'b1;
                state_next = S_DIV_HI;
            end
            S_DIV_HI, S_DIV_LO, S_DIV_INIT, S_DIV_STEP:
            begin
                case (state_reg)
                    S_DIV_HI:   cmd.div_op = DOP_HI;
                    S_DIV_LO:   cmd.div_op = DOP_LO;
                    S_DIV_INIT: cmd.div_op = DOP_INIT;
                    default:    cmd.div_op = DOP_STEP;
                endcase
                if (!launched_reg)
                begin
                    cmd.div_start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.div_done)
                begin
                    launched_next = 1'b0;
                    case (state_reg)
                        S_DIV_HI:
                        begin
                            cmd.take_hi = 1'b1;
                            state_next  = S_TEST;
                        end
                        S_DIV_LO:
                        begin
                            cmd.take_lo = 1'b1;
                            state_next  = S_DIV_INIT;
                        end
                        S_DIV_INIT:
                        begin
                            cmd.take_init = 1'b1;
                            state_next    = S_DIV_STEP;
                        end
                        default:
                        begin
                            cmd.take_step = 1'b1;
                            state_next    = S_TAPS;
                        end
                    endcase
                end
            end
            S_TEST:
            begin
                state_next = stat.not_ready ? S_FINISH : S_DIV_LO;
            end
            S_TAPS:
            begin
                cmd.tap_issue = 1'b1;
                if (stat.tap_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_DIV_OUT;
                end
            end
            S_DIV_OUT:
            begin
                cmd.div_op = DOP_OUT;
                if (stat.out_direct)
                begin
                    cmd.take_out = 1'b1;
                    state_next   = S_EMIT;
                end
                else if (!launched_reg)
                begin
                    cmd.div_start = 1'b1;
                    launched_next = 1'b1;
                end
                else if (stat.div_done)
                begin
                    launched_next = 1'b0;
                    cmd.take_out  = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next    = S_IDLE;
                launched_next = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/lz3_dp.sv
// Datapath: config registers, sample ring, position math, tap MAC and output register.
// Depends on lz3_pkg, lz3_ram and lz3_div.
module lz3_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lz3_pkg::lz3_cmd_t             cmd,
    output lz3_pkg::lz3_stat_t            stat,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [lz3_pkg::LEN_W-1:0]     cfg_data,
    input  logic [lz3_pkg::SAMPLE_W-1:0]  in_sample,
    input  logic                          in_eol,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lz3_pkg::SAMPLE_W-1:0]  m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);
    import lz3_pkg::*;

    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_DST = 1'b1;

    // Configuration registers.
    logic [LEN_W-1:0] src_len_reg, dst_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_len_reg <= LEN_W'(MAX_LEN);
            dst_len_reg <= LEN_W'(MAX_LEN);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SRC)
            begin
                src_len_reg <= cfg_data;
            end
            if (cfg_index == CFG_DST)
            begin
                dst_len_reg <= cfg_data;
            end
        end
    end

    // Clamped line geometry, latched with each sample.
    logic [LEN_W-1:0] src_cl, dst_cl, den_cl;
    logic [LEN_W+3:0] dst16;

    always_comb
    begin
        if (src_len_reg == '0)
            src_cl = LEN_W'(1);
        else if (src_len_reg > LEN_W'(MAX_LEN))
            src_cl = LEN_W'(MAX_LEN);
        else
            src_cl = src_len_reg;
        if (dst_len_reg == '0)
            dst_cl = LEN_W'(1);
        else if (dst_len_reg > src_cl)
            dst_cl = src_cl;
        else
            dst_cl = dst_len_reg;
        dst16  = (LEN_W+4)'(dst_cl) * (LEN_W+4)'(MAX_RATIO);
        den_cl = ((LEN_W+4)'(src_cl) > dst16) ? dst16[LEN_W-1:0] : src_cl;
    end

    logic [LEN_W-1:0]    src_reg, dst_reg, den_reg;
    logic [LEN_W-1:0]    n_reg, k_reg;
    logic [2:0]          count_reg;
    logic                eol_reg;
    logic [SAMPLE_W-1:0] first_reg;

    logic [LEN_W:0]   two_dst, two_den;
    logic [14:0]      six_den;
    logic [LEN_W-1:0] src_m1;

    assign two_dst = {dst_reg, 1'b0};
    assign two_den = {den_reg, 1'b0};
    assign six_den = 15'(den_reg) * 15'd6;
    assign src_m1  = src_reg - 1'b1;

    // Line counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            k_reg     <= '0;
            count_reg <= '0;
            first_reg <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                count_reg <= '0;
                if (n_reg == '0)
                begin
                    first_reg <= in_sample;
                end
            end
            if (cmd.out_write)
            begin
                k_reg     <= k_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                if ((n_reg + 1'b1 >= src_reg) || eol_reg)
                begin
                    n_reg <= '0;
                    k_reg <= '0;
                end
                else
                begin
                    n_reg <= n_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            src_reg <= src_cl;
            dst_reg <= dst_cl;
            den_reg <= den_cl;
            eol_reg <= in_eol;
        end
    end

    // Output centre term c = (2k+1)*src - dst.
    logic [25:0]       c_reg;
    logic [LEN_W+14:0] c_full;

    assign c_full = (LEN_W+15)'({k_reg, 1'b1}) * (LEN_W+15)'(src_reg) - (LEN_W+15)'(dst_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.calc_c)
        begin
            c_reg <= c_full[25:0];
        end
    end

    // Divider operand selection.
    logic [DVD_W-1:0] div_q;
    logic [DVS_W-1:0] div_r;
    logic             div_done;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             x_neg;
    logic [25:0]      x_mag;
    logic [13:0]      rlo_reg;

    logic signed [39:0] acc_reg;
    logic signed [23:0] wsum_reg;
    logic signed [41:0] numer;

    assign x_neg = c_reg < 26'(six_den);
    assign x_mag = x_neg ? 26'(six_den) - c_reg : c_reg - 26'(six_den);
    assign numer = 42'(acc_reg) * 42'sd2 + 42'(wsum_reg);

    always_comb
    begin
        case (cmd.div_op)
            DOP_HI:
            begin
                div_dvd = DVD_W'(c_reg) + DVD_W'(six_den);
                div_dvs = DVS_W'(two_dst);
            end
            DOP_LO:
            begin
                div_dvd = DVD_W'(x_mag);
                div_dvs = DVS_W'(two_dst);
            end
            DOP_INIT:
            begin
                div_dvd = DVD_W'({rlo_reg, 6'b0});
                div_dvs = DVS_W'(two_den);
            end
            DOP_STEP:
            begin
                div_dvd = DVD_W'({dst_reg, 7'b0});
                div_dvs = DVS_W'(two_den);
            end
            default:
            begin
                div_dvd = numer;
                div_dvs = {wsum_reg[DVS_W-2:0], 1'b0};
            end
        endcase
    end

    lz3_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // Tap window bounds and incremental kernel index state.
    logic [13:0]        hi_reg;
    logic signed [13:0] sx_reg;
    logic signed [10:0] qa_reg;
    logic [13:0]        ra_reg, rs_reg;
    logic [6:0]         qs_reg;
    logic               rnz;
    logic [13:0]        ra_sum_lo;
    logic [14:0]        ra_sum;
    logic               ra_wrap;

    assign rnz    = div_r[13:0] != '0;
    assign ra_sum = 15'(ra_reg) + 15'(rs_reg);
    assign ra_wrap = ra_sum >= 15'(two_den);
    assign ra_sum_lo = ra_wrap ? 14'(ra_sum - 15'(two_den)) : ra_sum[13:0];

    always_ff @(posedge clk)
    begin
        if (cmd.take_hi)
        begin
            hi_reg <= div_q[13:0];
        end
        if (cmd.take_lo)
        begin
            if (x_neg)
            begin
                sx_reg  <= -$signed(div_q[13:0] + 14'(rnz));
                rlo_reg <= rnz ? 14'(two_dst) - div_r[13:0] : '0;
            end
            else
            begin
                sx_reg  <= $signed(div_q[13:0]);
                rlo_reg <= div_r[13:0];
            end
        end
        if (cmd.take_init)
        begin
            qa_reg <= -$signed(11'(TAB_LEN) + 11'(div_q[6:0]) + 11'(rnz));
            ra_reg <= rnz ? 14'(two_den) - div_r[13:0] : '0;
        end
        if (cmd.take_step)
        begin
            qs_reg <= div_q[6:0];
            rs_reg <= div_r[13:0];
        end
        if (cmd.tap_issue)
        begin
            sx_reg <= sx_reg + 14'sd1;
            qa_reg <= qa_reg + $signed(11'(qs_reg)) + $signed(11'(ra_wrap));
            ra_reg <= ra_sum_lo;
        end
    end

    // Readiness: top = min(hi, src-1) must not pass the current sample.
    logic [13:0] top;
    assign top = (hi_reg > 14'(src_m1)) ? 14'(src_m1) : hi_reg;

    // Kernel index and clamped sample position of the current tap.
    logic signed [10:0] idx_full;
    logic               idx_skip;
    logic [IDX_W-1:0]   idx;
    logic [LEN_W-1:0]   csx;
    logic               ra_ge, ra_gt;

    assign ra_ge = ra_reg >= 14'(den_reg);
    assign ra_gt = ra_reg > 14'(den_reg);

    always_comb
    begin
        if (qa_reg[10])
            idx_full = -qa_reg - $signed(11'(ra_gt));
        else
            idx_full = qa_reg + $signed(11'(ra_ge));
        idx_skip = idx_full >= 11'sd192;
        idx      = idx_full[IDX_W-1:0];
        if (sx_reg < 14'sd0)
            csx = '0;
        else if (sx_reg > $signed({1'b0, src_m1}))
            csx = src_m1;
        else
            csx = sx_reg[LEN_W-1:0];
    end

    // Sample ring.
    logic [SAMPLE_W-1:0] ring_rdata;

    lz3_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.load_item),
        .waddr (n_reg[RING_AW-1:0]),
        .wdata (in_sample),
        .raddr (csx[RING_AW-1:0]),
        .rdata (ring_rdata)
    );

    // Tap pipeline: weight and read, then product, then accumulate.
    logic               p1_valid_reg, p2_valid_reg;
    logic signed [15:0] p1_w_reg, p2_w_reg;
    logic               p1_first_reg;
    logic signed [32:0] p2_prod_reg;
    logic [SAMPLE_W-1:0] tap_v;

    assign tap_v = p1_first_reg ? first_reg : ring_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.tap_issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_w_reg     <= idx_skip ? 16'sd0 : $signed(LZ_TABLE[idx]);
        p1_first_reg <= csx == '0;
        p2_w_reg     <= p1_w_reg;
        p2_prod_reg  <= p1_w_reg * $signed({1'b0, tap_v});
        if (cmd.take_lo)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (p2_valid_reg)
        begin
            acc_reg  <= acc_reg + 40'(p2_prod_reg);
            wsum_reg <= wsum_reg + 24'(p2_w_reg);
        end
    end

    // Normalized result with rounding and saturation.
    logic                out_direct;
    logic [SAMPLE_W-1:0] res_reg;
    logic                res_clip_reg;

    assign out_direct = (wsum_reg <= 24'sd0) || numer[41];

    always_ff @(posedge clk)
    begin
        if (cmd.take_out)
        begin
            if (out_direct)
            begin
                res_reg      <= '0;
                res_clip_reg <= 1'b1;
            end
            else if (div_q > DVD_W'(16'hFFFF))
            begin
                res_reg      <= 16'hFFFF;
                res_clip_reg <= 1'b1;
            end
            else
            begin
                res_reg      <= div_q[SAMPLE_W-1:0];
                res_clip_reg <= 1'b0;
            end
        end
    end

    // Output register.
    logic m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_write)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_write)
        begin
            m_tdata <= res_reg;
            m_tlast <= k_reg == dst_reg - 1'b1;
            m_tuser <= res_clip_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

    // Status back to the controller.
    always_comb
    begin
        stat.div_done   = div_done;
        stat.can_output = (count_reg < 3'(RESULT_CAP)) && (k_reg < dst_reg);
        stat.not_ready  = top > 14'(n_reg);
        stat.tap_last   = sx_reg == $signed(hi_reg);
        stat.pipe_busy  = p1_valid_reg || p2_valid_reg;
        stat.out_direct = out_direct;
        stat.out_free   = !m_valid_reg || m_tready;
    end

    // A new result never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_write |-> (!m_valid_reg || m_tready))
        else $error("output overwritten while stalled");

    // No more than the per-sample result cap.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_write |-> count_reg < 3'(RESULT_CAP))
        else $error("too many results for one sample");

    // Taps are issued only inside the window bounds.
    a_tap_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tap_issue |-> sx_reg <= $signed(hi_reg))
        else $error("tap issued past the window");

endmodule

FILE: rtl/lanczos3_line_downscaler.sv
// Top level of the Lanczos-3 line downscaler: controller plus datapath.
// Depends on lz3_pkg, lz3_ctrl and lz3_dp.
//
//  channel | direction | signals                                  | payload
//  s_      | in        | s_tvalid s_tready s_tdata s_tlast         | sample, end of line in tlast
//  m_      | out       | m_tvalid m_tready m_tdata m_tlast m_tuser | out_sample, last_out, clipped
//  cfg_    | in        | cfg_we cfg_index cfg_data                | 0: src_len, 1: dst_len
//
// One input beat is taken at a time. A beat that releases nothing only checks and finishes,
// plus one divider pass when a pending output is tested and found not ready.
// Each output released takes five divider passes, a pass over the kernel taps, a MAC drain
// and the step states (one pass fewer when the result saturates without a final divide);
// up to five outputs per beat.
// Reset clears all control state; the sample ring needs no clearing.
// A stalled output holds the controller only when a further result of the beat is ready.
module lanczos3_line_downscaler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lz3_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lz3_pkg::SAMPLE_W-1:0]  m_tdata,   // [15:0] out_sample
    output logic                          m_tlast,
    output logic                          m_tuser,   // [0] clipped
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [lz3_pkg::LEN_W-1:0]     cfg_data
);
    import lz3_pkg::*;

    lz3_cmd_t  cmd;
    lz3_stat_t stat;

    lz3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lz3_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_sample (s_tdata),
        .in_eol    (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
